[design/prdc_pkg.sv]
// ----------------------------------------------------------------------------
// Primary ray direction color package
// Shared payload types, register indexes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package prdc_pkg;

  localparam int PIX_W    = 12;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  localparam int RST_IMAGE_WIDTH  = 1920;
  localparam int RST_IMAGE_HEIGHT = 1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_COLOR_MODE   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } out_item_t;

  typedef struct packed {
    logic              raster;
    logic              shifted;
    logic [BYTE_W-1:0] red_raw;
    logic [BYTE_W-1:0] green_raw;
    logic [2:0]        neg;
  } ray_ctl_t;

endpackage

`default_nettype wire

[design/prdc_front.sv]
// ----------------------------------------------------------------------------
// Primary ray direction color front end
// Accepts pixels, forms the ray vector as sign and magnitude, and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module prdc_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire prdc_pkg::in_item_t        in_data,
  input  wire logic [COORD_BITS-1:0]     img_w,
  input  wire logic [COORD_BITS-1:0]     img_h,
  input  wire logic [prdc_pkg::MODE_W-1:0] mode,
  output logic                           q_valid,
  input  wire logic                      q_ready,
  output prdc_pkg::ray_ctl_t             q_ctl,
  output logic [2:0][COORD_BITS+1:0]     q_mag
);

  localparam int MAG_W = COORD_BITS + 2;
  localparam int D_W   = MAG_W + 1;

  logic [COORD_BITS-1:0] col, row;
  logic signed [D_W-1:0] dx, dy;
  prdc_pkg::ray_ctl_t    ctl_new;
  logic [2:0][MAG_W-1:0] mag_new;
  logic                  push_ok, pop_ok;

  prdc_pkg::ray_ctl_t    qc_r [prdc_pkg::QUEUE_DEPTH];
  logic [2:0][MAG_W-1:0] qm_r [prdc_pkg::QUEUE_DEPTH];
  logic [prdc_pkg::QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [prdc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    col = COORD_BITS'(in_data.pixel_col);
    row = COORD_BITS'(in_data.pixel_row);
    dx  = $signed({2'b00, col, 1'b1}) - $signed({3'b000, img_w});
    dy  = $signed({3'b000, img_h}) - $signed({2'b00, row, 1'b1});
    ctl_new.raster    = mode[1];
    ctl_new.shifted   = mode[0];
    ctl_new.red_raw   = col[7:0];
    ctl_new.green_raw = row[7:0];
    ctl_new.neg       = {1'b1, dy[D_W-1], dx[D_W-1]};
    mag_new[0] = dx[D_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    mag_new[1] = dy[D_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    mag_new[2] = MAG_W'(img_h);
  end

  assign in_full = (cnt_r == prdc_pkg::QCNT_W'(prdc_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_valid && q_ready;
  assign q_ctl   = qc_r[rp_r];
  assign q_mag   = qm_r[rp_r];

  always_comb begin
    wp_nxt  = push_ok ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop_ok ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + prdc_pkg::QCNT_W'(push_ok) - prdc_pkg::QCNT_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      qc_r[wp_r] <= ctl_new;
      qm_r[wp_r] <= mag_new;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= prdc_pkg::QCNT_W'(prdc_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

[design/prdc_back.sv]
// ----------------------------------------------------------------------------
// Primary ray direction color back end
// Squares, pipelined square root, pipelined division and byte mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module prdc_back #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire prdc_pkg::ray_ctl_t    q_ctl,
  input  wire logic [2:0][COORD_BITS+1:0] q_mag,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output prdc_pkg::out_item_t        out_data
);

  localparam int MAG_W = COORD_BITS + 2;
  localparam int LEN_W = MAG_W + 1;
  localparam int SQ_W  = 2 * MAG_W + 2;
  localparam int NS    = SQ_W / 2;
  localparam int R_W   = LEN_W + 3;
  localparam int REM_W = LEN_W + 1;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int ND    = FRAC_BITS;

  logic en;
  logic out_v_r;
  prdc_pkg::out_item_t out_r, out_nxt;

  assign en        = !out_v_r || out_pop;
  assign q_ready   = en;
  assign out_empty = !out_v_r;
  assign out_data  = out_r;

  logic                    v1_r, v2_r;
  prdc_pkg::ray_ctl_t      c1_r, c2_r;
  logic [2:0][MAG_W-1:0]   m1_r, m2_r;
  logic [2:0][2*MAG_W-1:0] sq1_r;

  logic                  sv_r  [NS+1];
  prdc_pkg::ray_ctl_t    sc_r  [NS+1];
  logic [2:0][MAG_W-1:0] sm_r  [NS+1];
  logic [SQ_W-1:0]       sx_r  [NS+1];
  logic [R_W-1:0]        sr_r  [NS+1];
  logic [LEN_W-1:0]      sq_r  [NS+1];

  logic                  dv_r  [ND+1];
  prdc_pkg::ray_ctl_t    dc_r  [ND+1];
  logic [LEN_W-1:0]      dl_r  [ND+1];
  logic [2:0][REM_W-1:0] dr_r  [ND+1];
  logic [2:0][Q_W-1:0]   dq_r  [ND+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= q_ctl;
      m1_r <= q_mag;
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= q_mag[i] * q_mag[i];
      end
      c2_r <= c1_r;
      m2_r <= m1_r;
    end
  end

  always_comb begin
    sv_r[0] = v2_r;
    sc_r[0] = c2_r;
    sm_r[0] = m2_r;
    sr_r[0] = '0;
    sq_r[0] = '0;
  end

  logic [SQ_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SQ_W'(sq1_r[0]) + SQ_W'(sq1_r[1]) + SQ_W'(sq1_r[2]);
    end
  end

  assign sx_r[0] = sum_r;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [R_W-1:0] rr, trial;
    logic           ge;
    always_comb begin
      rr    = {sr_r[k][R_W-3:0], sx_r[k][SQ_W-1 -: 2]};
      trial = {1'b0, sq_r[k], 2'b01};
      ge    = (rr >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sc_r[k+1] <= sc_r[k];
        sm_r[k+1] <= sm_r[k];
        sx_r[k+1] <= sx_r[k] << 2;
        sr_r[k+1] <= ge ? rr - trial : rr;
        sq_r[k+1] <= {sq_r[k][LEN_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= sv_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r[0] <= sc_r[NS];
      dl_r[0] <= sq_r[NS];
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, sm_r[NS][i]} >= sq_r[NS]) begin
          dr_r[0][i] <= REM_W'({1'b0, sm_r[NS][i]} - sq_r[NS]);
          dq_r[0][i] <= Q_W'(1);
        end else begin
          dr_r[0][i] <= REM_W'(sm_r[NS][i]);
          dq_r[0][i] <= '0;
        end
      end
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [2:0][REM_W-1:0] t;
    logic [2:0]            ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dr_r[j][i][REM_W-2:0], 1'b0};
        ge[i] = (t[i] >= {1'b0, dl_r[j]});
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dc_r[j+1] <= dc_r[j];
        dl_r[j+1] <= dl_r[j];
        for (int i = 0; i < 3; i++) begin
          dr_r[j+1][i] <= ge[i] ? t[i] - {1'b0, dl_r[j]} : t[i];
          dq_r[j+1][i] <= {dq_r[j][i][Q_W-2:0], ge[i]};
        end
      end
    end
  end

  function automatic logic [7:0] to_byte(input logic [Q_W-1:0] m, input logic neg,
                                         input logic shifted);
    logic [Q_W+7:0]       pa;
    logic [FRAC_BITS+1:0] tt;
    logic [FRAC_BITS+9:0] ps;
    logic [7:0]           res;
    pa = {m, 8'h00} - (Q_W+8)'(m);
    tt = neg ? (FRAC_BITS+2)'(1 << FRAC_BITS) - (FRAC_BITS+2)'(m)
             : (FRAC_BITS+2)'(1 << FRAC_BITS) + (FRAC_BITS+2)'(m);
    ps = {tt, 8'h00} - (FRAC_BITS+10)'(tt);
    if (shifted) begin
      res = ps[FRAC_BITS+8:FRAC_BITS+1];
    end else begin
      res = pa[FRAC_BITS+7:FRAC_BITS];
    end
    return res;
  endfunction

  always_comb begin
    if (dc_r[ND].raster) begin
      out_nxt.red   = dc_r[ND].red_raw;
      out_nxt.green = dc_r[ND].green_raw;
      out_nxt.blue  = '0;
    end else begin
      out_nxt.red   = to_byte(dq_r[ND][0], dc_r[ND].neg[0], dc_r[ND].shifted);
      out_nxt.green = to_byte(dq_r[ND][1], dc_r[ND].neg[1], dc_r[ND].shifted);
      out_nxt.blue  = to_byte(dq_r[ND][2], dc_r[ND].neg[2], dc_r[ND].shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_r[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[ND] && !dc_r[ND].raster) |->
      (dq_r[ND][0] <= Q_W'(1 << FRAC_BITS) && dq_r[ND][1] <= Q_W'(1 << FRAC_BITS) &&
       dq_r[ND][2] <= Q_W'(1 << FRAC_BITS)))
    else $error("normalized component above one");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_pop) |=> (out_v_r && $stable(out_r)))
    else $error("waiting result changed");
`endif

endmodule

`default_nettype wire

[design/primary_ray_direction_color_core.sv]
// ----------------------------------------------------------------------------
// Primary ray direction color core
// Pinhole camera primary ray per pixel, normalized and mapped to RGB bytes,
// or the low coordinate bytes in raster mode.
// Channel  Direction  Handshake          Payload
// in_      input      in_push / in_full  pixel_col, pixel_row
// out_     output     out_pop / out_empty red, green, blue
// cfg_     input      cfg_valid / ready  cfg_index, cfg_data
//
// One pixel is accepted per cycle while in_full is low, and one result leaves per cycle while out_pop is held.
// A result reaches the output ports after its request has passed the front
// queue, the square root pipeline of one stage per root bit and the divider
// of one stage per quotient bit.
// Reset is synchronous and clears all control state.
// A held result stalls the back pipeline; the front queue then fills.
// ----------------------------------------------------------------------------
`default_nettype none

module primary_ray_direction_color_core #(
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire prdc_pkg::in_item_t               in_data,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output prdc_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [prdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [prdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COORD_BITS = prdc_pkg::PIX_W;

  logic [COORD_BITS-1:0]         img_w_r, img_h_r;
  logic [prdc_pkg::MODE_W-1:0]   mode_r;
  logic                          q_valid, q_ready;
  prdc_pkg::ray_ctl_t            q_ctl;
  logic [2:0][COORD_BITS+1:0]    q_mag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= COORD_BITS'(prdc_pkg::RST_IMAGE_WIDTH);
      img_h_r <= COORD_BITS'(prdc_pkg::RST_IMAGE_HEIGHT);
      mode_r  <= '0;
    end else if (cfg_valid) begin
      unique case (prdc_pkg::cfg_index_t'(cfg_index))
        prdc_pkg::CFG_IMAGE_WIDTH:  img_w_r <= COORD_BITS'(cfg_data);
        prdc_pkg::CFG_IMAGE_HEIGHT: img_h_r <= COORD_BITS'(cfg_data);
        prdc_pkg::CFG_COLOR_MODE:   mode_r  <= cfg_data[prdc_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  prdc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .img_w   (img_w_r),
    .img_h   (img_h_r),
    .mode    (mode_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_ctl   (q_ctl),
    .q_mag   (q_mag)
  );

  prdc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_ctl     (q_ctl),
    .q_mag     (q_mag),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/sv/primary_ray_direction_color_core_checker.sv]
// ----------------------------------------------------------------------------
// Primary ray direction color checker
// Watches the pixel, result and register channels, predicts the color bytes
// of each accepted pixel request and compares them with the results in order.
// ----------------------------------------------------------------------------
module primary_ray_direction_color_core_checker (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  prdc_pkg::in_item_t  in_data,
  input  logic      out_empty,
  input  logic      out_pop,
  input  prdc_pkg::out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [prdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int        fail_count,
  output int        pending_colors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;

  logic [prdc_pkg::PIX_W-1:0]  width_reg;
  logic [prdc_pkg::PIX_W-1:0]  height_reg;
  logic [prdc_pkg::MODE_W-1:0] mode_reg;
  prdc_pkg::out_item_t         color_queue[$];

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [7:0] comp_byte(longint d, longint len,
                                           logic [prdc_pkg::MODE_W-1:0] mode);
    longint m;
    longint c;
    longint v;
    m = (len == 0) ? 0 : (((d < 0) ? -d : d) << FRAC) / len;
    c = (d < 0) ? -m : m;
    if (mode == 0) v = (m * 255) >>> FRAC;
    else v = ((c + (64'sd1 << FRAC)) * 255) >>> (FRAC + 1);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic prdc_pkg::out_item_t predict_color(prdc_pkg::in_item_t px);
    prdc_pkg::out_item_t r;
    longint dx;
    longint dy;
    longint dz;
    longint len;
    if (mode_reg[1]) begin
      r.red = px.pixel_col[7:0];
      r.green = px.pixel_row[7:0];
      r.blue = 8'd0;
      return r;
    end
    dx = 2 * longint'(px.pixel_col) + 1 - longint'(width_reg);
    dy = longint'(height_reg) - 2 * longint'(px.pixel_row) - 1;
    dz = -longint'(height_reg);
    len = int_sqrt(dx * dx + dy * dy + dz * dz);
    r.red = comp_byte(dx, len, mode_reg);
    r.green = comp_byte(dy, len, mode_reg);
    r.blue = comp_byte(dz, len, mode_reg);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_colors = color_queue.size();

  always @(posedge clk) begin
    prdc_pkg::out_item_t exp_c;
    if (!rst_n) begin
      width_reg <= prdc_pkg::PIX_W'(prdc_pkg::RST_IMAGE_WIDTH);
      height_reg <= prdc_pkg::PIX_W'(prdc_pkg::RST_IMAGE_HEIGHT);
      mode_reg <= '0;
    end else begin
      if (in_push && !in_full) color_queue.push_back(predict_color(in_data));
      if (out_pop && !out_empty) begin
        if (color_queue.size() == 0) begin
          report_mismatch("result without pending request");
        end else begin
          exp_c = color_queue.pop_front();
          if (out_data.red !== exp_c.red)
            report_mismatch($sformatf("red %0d, want %0d", out_data.red, exp_c.red));
          if (out_data.green !== exp_c.green)
            report_mismatch($sformatf("green %0d, want %0d", out_data.green, exp_c.green));
          if (out_data.blue !== exp_c.blue)
            report_mismatch($sformatf("blue %0d, want %0d", out_data.blue, exp_c.blue));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          prdc_pkg::CFG_IMAGE_WIDTH: width_reg <= cfg_data[prdc_pkg::PIX_W-1:0];
          prdc_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[prdc_pkg::PIX_W-1:0];
          prdc_pkg::CFG_COLOR_MODE: mode_reg <= cfg_data[prdc_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

[tb/sv/primary_ray_direction_color_core_test.sv]
// ----------------------------------------------------------------------------
// Primary ray direction color testbench
// Drives pixel requests under several image sizes and color modes with
// random gaps and result stalls; the checker predicts and compares colors.
// ----------------------------------------------------------------------------
module primary_ray_direction_color_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 16 + 12 + 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  prdc_pkg::in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  prdc_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [prdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [prdc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int        fail_count;
  int        pending_colors;
  logic      calm = 1'b0;

  always #6 clk = ~clk;

  primary_ray_direction_color_core uut (.*);
  primary_ray_direction_color_core_checker checker_i (.*);

  always @(posedge clk) out_pop <= calm || ($urandom_range(99) >= 28);

  task automatic write_reg(prdc_pkg::cfg_index_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= prdc_pkg::CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(int c, int r);
    while (!calm && $urandom_range(99) < 28) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{pixel_col: prdc_pkg::PIX_W'(c), pixel_row: prdc_pkg::PIX_W'(r)};
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (pending_colors != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int mode);
    write_reg(prdc_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(prdc_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(prdc_pkg::CFG_COLOR_MODE, mode);
  endtask

  initial begin
    int w;
    int h;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_pixel(0, 0);
    send_pixel(1919, 1079);
    send_pixel(4095, 4095);
    drain();
    for (int m = 0; m < 4; m++) begin
      set_frame(1, 1, m);
      send_pixel(0, 0);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      drain();
      set_frame(4095, 4095, m);
      send_pixel(0, 0);
      send_pixel(2047, 2047);
      send_pixel(4094, 4094);
      send_pixel(4095, 4095);
      drain();
    end
    set_frame(0, 0, 0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    drain();
    for (int ph = 0; ph < 14; ph++) begin
      w = (ph % 5 == 0) ? 4095 : $urandom_range(64, 1);
      h = (ph % 5 == 1) ? 4095 : $urandom_range(64, 1);
      set_frame(w, h, $urandom_range(3));
      calm = (ph == 6);
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(9) == 0) send_pixel($urandom_range(4095), $urandom_range(4095));
        else send_pixel($urandom_range(w - 1), $urandom_range(h - 1));
      end
      drain();
    end
    if (fail_count == 0) $display("[primary_ray_direction_color_core] OK");
    else $display("[primary_ray_direction_color_core] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[primary_ray_direction_color_core] ERROR");
    $finish;
  end
endmodule

[filelist.f]
design/prdc_pkg.sv
design/prdc_front.sv
design/prdc_back.sv
design/primary_ray_direction_color_core.sv
tb/sv/primary_ray_direction_color_core_checker.sv
tb/sv/primary_ray_direction_color_core_test.sv
